// File: sv/kbc_pkg.sv
`default_nettype none

package kbc_pkg;

  // fixed field widths of the transaction ports
  localparam int CMD_W    = 3;
  localparam int KEY_W    = 15;
  localparam int SIZE_W   = 9;
  localparam int IDX_W    = 8;
  localparam int WORD_W   = 16;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 13;

  // reset value of the low room limit register
  localparam logic [CFG_W-1:0] LOW_ROOM_RESET = 13'd50;

  typedef enum logic [CMD_W-1:0] {
    OP_WRITE = 3'd0,
    OP_PUT   = 3'd1,
    OP_GET   = 3'd2,
    OP_CLEAR = 3'd3,
    OP_READ  = 3'd4
  } kbc_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK         = 3'd0,
    STS_MISS       = 3'd1,
    STS_PRESENT    = 3'd2,
    STS_TABLE_FULL = 3'd3,
    STS_POOL_SHORT = 3'd4,
    STS_IGNORED    = 3'd5
  } kbc_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_STAGE_RD,
    ST_SEARCH,
    ST_COPY,
    ST_RESP
  } kbc_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic        latch;
    logic        stage_wr;
    logic        stage_rd_cap;
    logic        clear;
    logic        search_start;
    logic        commit_put;
    logic        copy_start;
    logic        copy_get;
    logic        set_full;
    logic        res_set;
    kbc_status_e res_code;
    logic        res_hit_size;
    logic        out_load;
  } kbc_ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             idx_ok;
    logic             size_bad;
    logic             full;
    logic             table_full;
    logic             pool_short;
    logic             room_low;
    logic             srch_hit;
    logic             srch_miss;
    logic             copy_done;
    logic             copy_busy;
    logic             out_free;
  } kbc_stat_t;

endpackage

`default_nettype wire

// File: sv/keyed_block_cache.sv
`default_nettype none

// channel  direction  handshake                 payload
// in       input      in_valid_i / in_ready_o   cmd_i key_i size_i index_i word_i
// out      output     out_valid_o / out_ready_i status_o size_out_o word_out_o is_full_o
// cfg      input      cfg_we_i (no wait)        cfg_wdata_i (low room limit)
//
// one transaction in flight at a time; put and get take longer with more used
// entries and larger blocks: the entry table is scanned one entry a cycle through
// its single read port and the block moves one word a cycle between staging
// buffer and pool
// asynchronous active-low reset clears the table count, pool use, full flag
// and sets the limit to 50; storage contents are not cleared
// the next transaction is accepted while a result still waits on out; only a
// second finished result waits for the output register to drain

module keyed_block_cache
  import kbc_pkg::*;
#(
  parameter int ENTRIES     = 64,
  parameter int POOL_WORDS  = 4096,
  parameter int STAGE_WORDS = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [CMD_W-1:0]    cmd_i,
  input  wire logic [KEY_W-1:0]    key_i,
  input  wire logic [SIZE_W-1:0]   size_i,
  input  wire logic [IDX_W-1:0]    index_i,
  input  wire logic [WORD_W-1:0]   word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [SIZE_W-1:0]        size_out_o,
  output logic [WORD_W-1:0]        word_out_o,
  output logic                     is_full_o
);

  // command and status between sequencer and datapath
  kbc_ctrl_t ctrl;
  kbc_stat_t stat;

  // sequencer: decode, search, copy and result hand-off
  kbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // datapath: entry table, pool, staging buffer, counters, output register
  kbc_dpath #(
    .ENTRIES     (ENTRIES),
    .POOL_WORDS  (POOL_WORDS),
    .STAGE_WORDS (STAGE_WORDS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .size_i      (size_i),
    .index_i     (index_i),
    .word_i      (word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .size_out_o  (size_out_o),
    .word_out_o  (word_out_o),
    .is_full_o   (is_full_o),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

  // an accepted transaction is never followed by another acceptance in the next cycle
  a_accept_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // a finished result never overwrites one that still waits
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> stat.out_free)
    else $error("output register overwritten");

  // no transaction is taken while a block copy runs
  a_no_accept_in_copy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.latch |-> !stat.copy_busy)
    else $error("transaction accepted during copy");

endmodule

`default_nettype wire

// File: sv/kbc_ctrl.sv
`default_nettype none

module kbc_ctrl
  import kbc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire kbc_stat_t stat_i,
  output kbc_ctrl_t      ctrl_o
);

  kbc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.latch = 1'b1;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        ctrl_o.res_set = 1'b1;
        state_d        = ST_RESP;
        unique case (stat_i.op)
          OP_WRITE: begin
            if (stat_i.idx_ok) begin
              ctrl_o.stage_wr = 1'b1;
              ctrl_o.res_code = STS_OK;
            end else begin
              ctrl_o.res_code = STS_IGNORED;
            end
          end
          OP_READ: begin
            if (stat_i.idx_ok) begin
              ctrl_o.res_code = STS_OK;
              state_d         = ST_STAGE_RD;
            end else begin
              ctrl_o.res_code = STS_IGNORED;
            end
          end
          OP_CLEAR: begin
            ctrl_o.clear    = 1'b1;
            ctrl_o.res_code = STS_OK;
          end
          OP_PUT: begin
            if (stat_i.size_bad) begin
              ctrl_o.res_code = STS_IGNORED;
            end else if (stat_i.full) begin
              ctrl_o.res_code = STS_TABLE_FULL;
            end else begin
              ctrl_o.res_set      = 1'b0;
              ctrl_o.search_start = 1'b1;
              state_d             = ST_SEARCH;
            end
          end
          OP_GET: begin
            ctrl_o.res_set      = 1'b0;
            ctrl_o.search_start = 1'b1;
            state_d             = ST_SEARCH;
          end
          default: begin
            ctrl_o.res_code = STS_IGNORED;
          end
        endcase
      end
      ST_STAGE_RD: begin
        ctrl_o.stage_rd_cap = 1'b1;
        state_d             = ST_RESP;
      end
      ST_SEARCH: begin
        if (stat_i.srch_hit) begin
          ctrl_o.res_set = 1'b1;
          if (stat_i.op == OP_GET) begin
            ctrl_o.res_code     = STS_OK;
            ctrl_o.res_hit_size = 1'b1;
            ctrl_o.copy_start   = 1'b1;
            ctrl_o.copy_get     = 1'b1;
            state_d             = ST_COPY;
          end else begin
            ctrl_o.res_code = STS_PRESENT;
            state_d         = ST_RESP;
          end
        end else if (stat_i.srch_miss) begin
          ctrl_o.res_set = 1'b1;
          state_d        = ST_RESP;
          if (stat_i.op == OP_GET) begin
            ctrl_o.res_code = STS_MISS;
          end else if (stat_i.table_full) begin
            ctrl_o.set_full = 1'b1;
            ctrl_o.res_code = STS_TABLE_FULL;
          end else if (stat_i.pool_short) begin
            ctrl_o.set_full = stat_i.room_low;
            ctrl_o.res_code = STS_POOL_SHORT;
          end else begin
            ctrl_o.res_code   = STS_OK;
            ctrl_o.commit_put = 1'b1;
            ctrl_o.copy_start = 1'b1;
            state_d           = ST_COPY;
          end
        end
      end
      ST_COPY: begin
        if (stat_i.copy_done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/kbc_dpath.sv
`default_nettype none

module kbc_dpath
  import kbc_pkg::*;
#(
  parameter int ENTRIES     = 64,
  parameter int POOL_WORDS  = 4096,
  parameter int STAGE_WORDS = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CFG_W-1:0]    cfg_wdata_i,
  input  wire logic [CMD_W-1:0]    cmd_i,
  input  wire logic [KEY_W-1:0]    key_i,
  input  wire logic [SIZE_W-1:0]   size_i,
  input  wire logic [IDX_W-1:0]    index_i,
  input  wire logic [WORD_W-1:0]   word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [SIZE_W-1:0]        size_out_o,
  output logic [WORD_W-1:0]        word_out_o,
  output logic                     is_full_o,
  input  wire kbc_ctrl_t           ctrl_i,
  output kbc_stat_t                stat_o
);

  localparam int EW   = $clog2(ENTRIES);
  localparam int UW   = $clog2(ENTRIES + 1);
  localparam int PW   = $clog2(POOL_WORDS);
  localparam int PUW  = $clog2(POOL_WORDS + 1);
  localparam int SW   = $clog2(STAGE_WORDS);
  localparam int CW   = (PUW > CFG_W) ? PUW : CFG_W;
  localparam int SUMW = ((PUW > SIZE_W) ? PUW : SIZE_W) + 1;

  // latched transaction
  logic [CMD_W-1:0]  cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [SIZE_W-1:0] size_q;
  logic [IDX_W-1:0]  idx_q;
  logic [WORD_W-1:0] word_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q  <= cmd_i;
      key_q  <= key_i;
      size_q <= size_i;
      idx_q  <= index_i;
      word_q <= word_i;
    end
  end

  // configuration and bookkeeping
  logic [CFG_W-1:0] limit_q;
  logic [UW-1:0]    used_q;
  logic [PUW-1:0]   pool_used_q;
  logic             full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LOW_ROOM_RESET;
      used_q      <= '0;
      pool_used_q <= '0;
      full_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (ctrl_i.clear) begin
        used_q      <= '0;
        pool_used_q <= '0;
        full_q      <= 1'b0;
      end else begin
        if (ctrl_i.commit_put) begin
          used_q      <= used_q + UW'(1);
          pool_used_q <= pool_used_q + PUW'(size_q);
        end
        if (ctrl_i.set_full) begin
          full_q <= 1'b1;
        end
      end
    end
  end

  logic [PUW-1:0]  room;
  logic [SUMW-1:0] pool_sum;
  assign room     = PUW'(POOL_WORDS) - pool_used_q;
  assign pool_sum = SUMW'(pool_used_q) + SUMW'(size_q);

  // entry table
  logic [KEY_W-1:0]  ent_key_mem  [ENTRIES];
  logic [SIZE_W-1:0] ent_size_mem [ENTRIES];
  logic [PW-1:0]     ent_base_mem [ENTRIES];
  logic [KEY_W-1:0]  ent_key_q;
  logic [SIZE_W-1:0] ent_size_q;
  logic [PW-1:0]     ent_base_q;

  logic [UW-1:0] srch_ptr_q;
  logic          srch_act_q;
  logic          chk_v_q;
  logic          srch_hit;
  logic          srch_miss;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit_put) begin
      ent_key_mem[used_q[EW-1:0]]  <= key_q;
      ent_size_mem[used_q[EW-1:0]] <= size_q;
      ent_base_mem[used_q[EW-1:0]] <= pool_used_q[PW-1:0];
    end
    ent_key_q  <= ent_key_mem[srch_ptr_q[EW-1:0]];
    ent_size_q <= ent_size_mem[srch_ptr_q[EW-1:0]];
    ent_base_q <= ent_base_mem[srch_ptr_q[EW-1:0]];
  end

  // linear search, one entry read issued per cycle, compared in the next cycle on the registered entry
  assign srch_hit  = srch_act_q && chk_v_q && (ent_key_q == key_q);
  assign srch_miss = srch_act_q && !chk_v_q && (srch_ptr_q >= used_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srch_act_q <= 1'b0;
      srch_ptr_q <= '0;
      chk_v_q    <= 1'b0;
    end else if (ctrl_i.search_start) begin
      srch_act_q <= 1'b1;
      srch_ptr_q <= '0;
      chk_v_q    <= 1'b0;
    end else if (srch_act_q) begin
      if (srch_hit || srch_miss) begin
        srch_act_q <= 1'b0;
        chk_v_q    <= 1'b0;
      end else if (srch_ptr_q < used_q) begin
        srch_ptr_q <= srch_ptr_q + UW'(1);
        chk_v_q    <= 1'b1;
      end else begin
        chk_v_q <= 1'b0;
      end
    end
  end

  // copy engine between staging buffer and pool
  logic              cp_act_q;
  logic              cp_get_q;
  logic [SIZE_W-1:0] cp_cnt_q;
  logic [PW-1:0]     cp_pool_q;
  logic [SW-1:0]     cp_stage_q;
  logic              wr_v_q;
  logic [PW-1:0]     wr_pool_a_q;
  logic [SW-1:0]     wr_stage_a_q;
  logic              copy_done;

  assign copy_done = cp_act_q && (cp_cnt_q == '0) && !wr_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_act_q <= 1'b0;
      cp_get_q <= 1'b0;
      cp_cnt_q <= '0;
      wr_v_q   <= 1'b0;
    end else if (ctrl_i.copy_start) begin
      cp_act_q <= 1'b1;
      cp_get_q <= ctrl_i.copy_get;
      cp_cnt_q <= ctrl_i.copy_get ? ent_size_q : size_q;
      wr_v_q   <= 1'b0;
    end else if (cp_act_q) begin
      if (cp_cnt_q != '0) begin
        cp_cnt_q <= cp_cnt_q - SIZE_W'(1);
        wr_v_q   <= 1'b1;
      end else begin
        wr_v_q <= 1'b0;
        if (!wr_v_q) begin
          cp_act_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.copy_start) begin
      cp_pool_q  <= ctrl_i.copy_get ? ent_base_q : pool_used_q[PW-1:0];
      cp_stage_q <= '0;
    end else if (cp_act_q && (cp_cnt_q != '0)) begin
      cp_pool_q    <= cp_pool_q + PW'(1);
      cp_stage_q   <= cp_stage_q + SW'(1);
      wr_pool_a_q  <= cp_pool_q;
      wr_stage_a_q <= cp_stage_q;
    end
  end

  // staging buffer
  logic [WORD_W-1:0] stage_mem [STAGE_WORDS];
  logic [WORD_W-1:0] stage_rdata_q;
  logic [WORD_W-1:0] pool_rdata_q;
  logic              stage_we;
  logic [SW-1:0]     stage_wa;
  logic [WORD_W-1:0] stage_wd;
  logic [SW-1:0]     stage_ra;

  assign stage_we = ctrl_i.stage_wr || (wr_v_q && cp_get_q);
  assign stage_wa = ctrl_i.stage_wr ? SW'(idx_q) : wr_stage_a_q;
  assign stage_wd = ctrl_i.stage_wr ? word_q : pool_rdata_q;
  assign stage_ra = cp_act_q ? cp_stage_q : SW'(idx_q);

  always_ff @(posedge clk_i) begin
    if (stage_we) begin
      stage_mem[stage_wa] <= stage_wd;
    end
    stage_rdata_q <= stage_mem[stage_ra];
  end

  // block pool
  logic [WORD_W-1:0] pool_mem [POOL_WORDS];

  always_ff @(posedge clk_i) begin
    if (wr_v_q && !cp_get_q) begin
      pool_mem[wr_pool_a_q] <= stage_rdata_q;
    end
    pool_rdata_q <= pool_mem[cp_pool_q];
  end

  // result and output register
  kbc_status_e       res_status_q;
  logic [SIZE_W-1:0] res_size_q;
  logic [WORD_W-1:0] res_word_q;
  logic              out_valid_q;
  logic              out_free;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      res_size_q <= '0;
      res_word_q <= '0;
    end else begin
      if (ctrl_i.res_hit_size) begin
        res_size_q <= ent_size_q;
      end
      if (ctrl_i.stage_rd_cap) begin
        res_word_q <= stage_rdata_q;
      end
    end
    if (ctrl_i.res_set) begin
      res_status_q <= ctrl_i.res_code;
    end
    if (ctrl_i.out_load) begin
      status_o   <= res_status_q;
      size_out_o <= res_size_q;
      word_out_o <= res_word_q;
      is_full_o  <= full_q;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    stat_o            = '0;
    stat_o.op         = cmd_q;
    stat_o.idx_ok     = 32'(idx_q) < 32'(STAGE_WORDS);
    stat_o.size_bad   = (size_q == '0) || (32'(size_q) > 32'(STAGE_WORDS));
    stat_o.full       = full_q;
    stat_o.table_full = used_q >= UW'(ENTRIES - 1);
    stat_o.pool_short = pool_sum >= SUMW'(POOL_WORDS);
    stat_o.room_low   = CW'(room) < CW'(limit_q);
    stat_o.srch_hit   = srch_hit;
    stat_o.srch_miss  = srch_miss;
    stat_o.copy_done  = copy_done;
    stat_o.copy_busy  = cp_act_q;
    stat_o.out_free   = out_free;
  end

endmodule

`default_nettype wire

// File: dv/keyed_block_cache_tb.sv
`default_nettype none

module keyed_block_cache_tb;
  import kbc_pkg::*;

  localparam int ENTRIES       = 64;
  localparam int POOL_WORDS    = 4096;
  localparam int STAGE_WORDS   = 256;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 190;
  localparam int SETTLE_CYCLES = 20;
  // the limit covers the slowest transaction plus output stalls and sender gaps
  localparam int STALL_LIMIT   = 4000;

  // command codes the block has no operation for
  localparam logic [CMD_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    kbc_status_e       status;
    logic [SIZE_W-1:0] size_out;
    logic [WORD_W-1:0] word_out;
    logic              is_full;
  } cache_reply_t;

  // one row of the directed sequence; reply is used only when typed is set
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] word;
    logic              typed;
    cache_reply_t      reply;
  } probe_row_t;

  typedef enum logic [1:0] {FILL_SMALL, FILL_LARGE, FILL_MIXED} fill_mode_e;
  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_style_e;

  localparam int PROBE_ROWS = 23;
  // staging holds random words from the preload when the table is walked
  probe_row_t probe_rows [PROBE_ROWS] = '{
    // cmd      key       size     index  word       typed  status size_out word_out full
    '{OP_READ,  15'h0000, 9'd0,   8'd0,   16'h0000, 1'b0, '{STS_OK,         9'd0,   16'h0000, 1'b0}},
    '{OP_READ,  15'h0000, 9'd0,   8'd255, 16'h0000, 1'b0, '{STS_OK,         9'd0,   16'h0000, 1'b0}},
    '{OP_GET,   15'h0000, 9'd0,   8'd0,   16'h0000, 1'b1, '{STS_MISS,       9'd0,   16'h0000, 1'b0}},
    '{OP_PUT,   15'h7fff, 9'd0,   8'd0,   16'h0000, 1'b1, '{STS_IGNORED,    9'd0,   16'h0000, 1'b0}},
    '{OP_PUT,   15'h7fff, 9'd511, 8'd0,   16'h0000, 1'b1, '{STS_IGNORED,    9'd0,   16'h0000, 1'b0}},
    '{OP_PUT,   15'h7fff, 9'd257, 8'd0,   16'h0000, 1'b1, '{STS_IGNORED,    9'd0,   16'h0000, 1'b0}},
    '{OP_PUT,   15'h7fff, 9'd256, 8'd0,   16'h0000, 1'b1, '{STS_OK,         9'd0,   16'h0000, 1'b0}},
    '{OP_PUT,   15'h7fff, 9'd5,   8'd0,   16'h0000, 1'b1, '{STS_PRESENT,    9'd0,   16'h0000, 1'b0}},
    '{OP_WRITE, 15'h0000, 9'd0,   8'd255, 16'hffff, 1'b1, '{STS_OK,         9'd0,   16'h0000, 1'b0}},
    '{OP_WRITE, 15'h7fff, 9'd511, 8'd0,   16'h0000, 1'b1, '{STS_OK,         9'd0,   16'h0000, 1'b0}},
    '{OP_READ,  15'h0000, 9'd0,   8'd255, 16'h0000, 1'b1, '{STS_OK,         9'd0,   16'hffff, 1'b0}},
    '{OP_READ,  15'h0000, 9'd0,   8'd0,   16'hffff, 1'b1, '{STS_OK,         9'd0,   16'h0000, 1'b0}},
    // get refills staging from the pool copy of the 256-word block
    '{OP_GET,   15'h7fff, 9'd0,   8'd0,   16'h0000, 1'b1, '{STS_OK,         9'd256, 16'h0000, 1'b0}},
    '{OP_READ,  15'h0000, 9'd0,   8'd0,   16'h0000, 1'b0, '{STS_OK,         9'd0,   16'h0000, 1'b0}},
    '{OP_READ,  15'h0000, 9'd0,   8'd255, 16'h0000, 1'b0, '{STS_OK,         9'd0,   16'h0000, 1'b0}},
    '{OP_PUT,   15'h0000, 9'd1,   8'd0,   16'h0000, 1'b1, '{STS_OK,         9'd0,   16'h0000, 1'b0}},
    '{OP_GET,   15'h0000, 9'd0,   8'd0,   16'h0000, 1'b1, '{STS_OK,         9'd1,   16'h0000, 1'b0}},
    '{OP_RSVD5, 15'h7fff, 9'd511, 8'd255, 16'hffff, 1'b1, '{STS_IGNORED,    9'd0,   16'h0000, 1'b0}},
    '{OP_RSVD6, 15'h5555, 9'd256, 8'd128, 16'haaaa, 1'b1, '{STS_IGNORED,    9'd0,   16'h0000, 1'b0}},
    '{OP_RSVD7, 15'h0000, 9'd0,   8'd0,   16'h0000, 1'b1, '{STS_IGNORED,    9'd0,   16'h0000, 1'b0}},
    '{OP_CLEAR, 15'h0000, 9'd0,   8'd0,   16'h0000, 1'b1, '{STS_OK,         9'd0,   16'h0000, 1'b0}},
    '{OP_GET,   15'h7fff, 9'd0,   8'd0,   16'h0000, 1'b1, '{STS_MISS,       9'd0,   16'h0000, 1'b0}},
    '{OP_PUT,   15'h2aaa, 9'd3,   8'd0,   16'h0000, 1'b1, '{STS_OK,         9'd0,   16'h0000, 1'b0}}
  };

  // block ports; the inputs are known from time zero
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [CMD_W-1:0]   cmd_i       = '0;
  logic [KEY_W-1:0]   key_i       = '0;
  logic [SIZE_W-1:0]  size_i      = '0;
  logic [IDX_W-1:0]   index_i     = '0;
  logic [WORD_W-1:0]  word_i      = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [SIZE_W-1:0]  size_out_o;
  logic [WORD_W-1:0]  word_out_o;
  logic               is_full_o;

  // mirror of the cache contents, kept in step with accepted transactions
  logic [KEY_W-1:0]   key_tbl  [ENTRIES];
  logic [SIZE_W-1:0]  size_tbl [ENTRIES];
  logic [11:0]        base_tbl [ENTRIES];
  logic [WORD_W-1:0]  pool_mem [POOL_WORDS];
  logic [WORD_W-1:0]  stage_mem [STAGE_WORDS];
  int                 entry_count = 0;
  int                 pool_fill   = 0;
  logic               cache_full  = 1'b0;
  int                 room_limit  = int'(LOW_ROOM_RESET);

  cache_reply_t       reply_q [$];
  cache_reply_t       oldest_reply;
  int                 fail_count  = 0;
  int                 burst_left  = 0;
  int                 stall_count = 0;
  ready_style_e       ready_style = RDY_ALWAYS;
  int                 ready_span  = 0;

  keyed_block_cache #(
    .ENTRIES     (ENTRIES),
    .POOL_WORDS  (POOL_WORDS),
    .STAGE_WORDS (STAGE_WORDS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .size_i      (size_i),
    .index_i     (index_i),
    .word_i      (word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .size_out_o  (size_out_o),
    .word_out_o  (word_out_o),
    .is_full_o   (is_full_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // linear scan of the used entries, -1 on a miss
  function automatic int find_slot(input logic [KEY_W-1:0] k);
    int i;
    for (i = 0; i < entry_count && i < ENTRIES; i++) begin
      if (key_tbl[i] == k) return i;
    end
    return -1;
  endfunction

  // applies one transaction to the mirror and returns the reply it should get
  function automatic cache_reply_t predict_reply(input logic [CMD_W-1:0] op,
                                                 input logic [KEY_W-1:0] k,
                                                 input logic [SIZE_W-1:0] sz,
                                                 input logic [IDX_W-1:0] ix,
                                                 input logic [WORD_W-1:0] wd);
    cache_reply_t r;
    int slot;
    int base;
    int i;
    r = '{status: STS_IGNORED, size_out: '0, word_out: '0, is_full: 1'b0};
    case (op)
      OP_WRITE: begin
        if (int'(ix) < STAGE_WORDS) begin
          stage_mem[ix] = wd;
          r.status = STS_OK;
        end
      end
      OP_PUT: begin
        // checks are ordered: bad size, full flag, key present, table, pool
        if (sz == '0 || int'(sz) > STAGE_WORDS) begin
          r.status = STS_IGNORED;
        end else if (cache_full) begin
          r.status = STS_TABLE_FULL;
        end else if (find_slot(k) >= 0) begin
          r.status = STS_PRESENT;
        end else if (entry_count >= ENTRIES - 1) begin
          cache_full = 1'b1;
          r.status = STS_TABLE_FULL;
        end else if (pool_fill + int'(sz) >= POOL_WORDS) begin
          // the last pool word can never be allocated
          if (POOL_WORDS - pool_fill < room_limit) cache_full = 1'b1;
          r.status = STS_POOL_SHORT;
        end else begin
          key_tbl[entry_count]  = k;
          size_tbl[entry_count] = sz;
          base_tbl[entry_count] = 12'(pool_fill);
          for (i = 0; i < int'(sz); i++) pool_mem[pool_fill + i] = stage_mem[i];
          pool_fill += int'(sz);
          entry_count++;
          r.status = STS_OK;
        end
      end
      OP_GET: begin
        slot = find_slot(k);
        if (slot < 0) begin
          r.status = STS_MISS;
        end else begin
          base = int'(base_tbl[slot]);
          for (i = 0; i < int'(size_tbl[slot]) && i < STAGE_WORDS
                      && base + i < POOL_WORDS; i++) begin
            stage_mem[i] = pool_mem[base + i];
          end
          r.size_out = size_tbl[slot];
          r.status = STS_OK;
        end
      end
      OP_CLEAR: begin
        // pool and staging contents stay
        entry_count = 0;
        pool_fill   = 0;
        cache_full  = 1'b0;
        r.status    = STS_OK;
      end
      OP_READ: begin
        if (int'(ix) < STAGE_WORDS) begin
          r.word_out = stage_mem[ix];
          r.status = STS_OK;
        end
      end
      default: r.status = STS_IGNORED;
    endcase
    r.is_full = cache_full;
    return r;
  endfunction

  // queues the expected reply, then offers the transaction until accepted;
  // the sender runs in bursts separated by random gaps
  task automatic issue(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k,
                       input logic [SIZE_W-1:0] sz, input logic [IDX_W-1:0] ix,
                       input logic [WORD_W-1:0] wd, input logic typed,
                       input cache_reply_t typed_reply);
    cache_reply_t predicted;
    predicted = predict_reply(op, k, sz, ix, wd);
    reply_q.push_back(typed ? typed_reply : predicted);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cmd_i      <= op;
    key_i      <= k;
    size_i     <= sz;
    index_i    <= ix;
    word_i     <= wd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // register writes only with nothing in flight
  task automatic write_room_limit(input int v);
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_W'(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    room_limit = v;
  endtask

  // receiver stalls in spans of one style at a time
  always @(posedge clk_i) begin
    if (ready_span == 0) begin
      ready_style <= ready_style_e'($urandom_range(0, 3));
      ready_span  <= $urandom_range(16, 96);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_style)
      RDY_ALWAYS: out_ready_i <= 1'b1;
      RDY_COIN:   out_ready_i <= ($urandom_range(0, 1) == 1);
      RDY_SPARSE: out_ready_i <= ($urandom_range(0, 7) == 0);
      default:    out_ready_i <= (ready_span[1:0] == 2'd0);
    endcase
  end

  // every returned transaction is matched against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected reply status %0d size %0d word %h full %0b",
                 $time, status_o, size_out_o, word_out_o, is_full_o);
        fail_count++;
      end else begin
        oldest_reply = reply_q.pop_front();
        if (status_o !== oldest_reply.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, oldest_reply.status, status_o);
          fail_count++;
        end
        if (size_out_o !== oldest_reply.size_out) begin
          $display("%0t: size_out expected %0d actual %0d",
                   $time, oldest_reply.size_out, size_out_o);
          fail_count++;
        end
        if (word_out_o !== oldest_reply.word_out) begin
          $display("%0t: word_out expected %h actual %h",
                   $time, oldest_reply.word_out, word_out_o);
          fail_count++;
        end
        if (is_full_o !== oldest_reply.is_full) begin
          $display("%0t: is_full expected %0b actual %0b",
                   $time, oldest_reply.is_full, is_full_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog: too long without any transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    cache_reply_t       no_reply;
    int                 p;
    int                 n;
    int                 pick;
    int                 limits [PHASES];
    fill_mode_e         modes  [PHASES];
    fill_mode_e         mode;
    logic [CMD_W-1:0]   op;
    logic [KEY_W-1:0]   k;
    logic [SIZE_W-1:0]  sz;
    logic [IDX_W-1:0]   ix;
    logic [WORD_W-1:0]  wd;

    no_reply = '0;
    // limit extremes first, then a random one; large blocks drain the pool,
    // small ones fill the table
    limits = '{4096, 0, 4095, 1, $urandom_range(0, 4096)};
    modes  = '{FILL_LARGE, FILL_SMALL, FILL_LARGE, FILL_SMALL, FILL_MIXED};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole staging buffer so no copy or read touches unwritten words
    for (n = 0; n < STAGE_WORDS; n++) begin
      issue(OP_WRITE, 15'($urandom), 9'($urandom), 8'(n), 16'($urandom), 1'b0, no_reply);
    end

    for (n = 0; n < PROBE_ROWS; n++) begin
      issue(probe_rows[n].cmd, probe_rows[n].key, probe_rows[n].size,
            probe_rows[n].index, probe_rows[n].word, probe_rows[n].typed,
            probe_rows[n].reply);
    end

    for (p = 0; p < PHASES; p++) begin
      write_room_limit(limits[p]);
      mode = modes[p];
      issue(OP_CLEAR, 15'($urandom), 9'($urandom), 8'($urandom), 16'($urandom),
            1'b0, no_reply);
      for (n = 1; n < PHASE_ITEMS; n++) begin
        k    = 15'($urandom);
        sz   = 9'($urandom);
        ix   = 8'($urandom);
        wd   = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          op = OP_WRITE;
        end else if (pick < 18) begin
          op = OP_READ;
        end else if (pick < 68) begin
          op = OP_PUT;
          // mostly fresh keys so the table keeps growing
          if (entry_count > 0 && $urandom_range(0, 9) < 2) begin
            k = key_tbl[$urandom_range(0, entry_count - 1)];
          end
          if ($urandom_range(0, 19) == 0) begin
            sz = ($urandom_range(0, 1) == 1) ? 9'd0 : 9'($urandom_range(257, 511));
          end else begin
            case (mode)
              FILL_SMALL: sz = 9'($urandom_range(1, 24));
              FILL_LARGE: sz = ($urandom_range(0, 3) == 0) ? 9'd256
                                                         : 9'($urandom_range(128, 256));
              default:    sz = 9'($urandom_range(1, 256));
            endcase
          end
        end else if (pick < 94) begin
          op = OP_GET;
          if (entry_count > 0 && $urandom_range(0, 9) < 7) begin
            k = key_tbl[$urandom_range(0, entry_count - 1)];
          end
        end else if (pick < 96 && mode == FILL_MIXED) begin
          op = OP_CLEAR;
        end else begin
          case ($urandom_range(0, 2))
            0:       op = OP_RSVD5;
            1:       op = OP_RSVD6;
            default: op = OP_RSVD7;
          endcase
        end
        issue(op, k, sz, ix, wd, 1'b0, no_reply);
      end
    end

    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: keyed_block_cache.f
sv/kbc_pkg.sv
sv/kbc_ctrl.sv
sv/kbc_dpath.sv
sv/keyed_block_cache.sv
dv/keyed_block_cache_tb.sv
